/* design/pzb_pkg.sv */
// Package for the perspective z-buffer point plot unit.
// Holds field widths, status and register codes, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package pzb_pkg;

    // Field widths of the channels and the configuration port.
    localparam int COORD_W    = 32;
    localparam int COLOR_W    = 24;
    localparam int SCALE_W    = 32;
    localparam int NEAR_W     = 31;
    localparam int DEPTH_W    = 32;
    localparam int PIX_X_W    = 10;
    localparam int PIX_Y_W    = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Arithmetic widths. A positive depth fits in 31 bits, and the product
    // of a coordinate magnitude and the scale needs 64 bits.
    localparam int Z_W    = 31;
    localparam int PROD_W = 64;
    localparam int FRAC_W = 16;
    // Quotient bits kept: a quotient of 2**13 or more is off screen for any
    // supported screen size.
    localparam int QBITS  = 13;
    localparam int CNT_W  = 4;
    // Signed screen positions before the range check.
    localparam int POS_W  = 16;

    localparam logic [DEPTH_W-1:0]  FAR_DEPTH   = 32'hFFFF_FFFF;
    localparam logic [SCALE_W-1:0]  SCALE_RESET = 32'd36323741;
    localparam logic [NEAR_W-1:0]   NEAR_RESET  = 31'd66;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_DRAWN   = 2'd0,
        STAT_OFF     = 2'd1,
        STAT_HIDDEN  = 2'd2,
        STAT_CLEARED = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    cap_in;
        logic    clr_step;
        logic    mul_go;
        logic    div_load;
        logic    div_step;
        logic    round_go;
        logic    axis;
        logic    addr_go;
        logic    depth_wr;
        logic    out_load;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;
        logic too_near;
        logic div_ovf;
        logic div_last;
        logic off_screen;
        logic depth_win;
        logic sweep_last;
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/pzb_pt_if.sv */
// Input channel interface: one point or clear request per transaction.
// Depends on pzb_pkg.
`default_nettype none

interface pzb_pt_if import pzb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] depth_z;
    logic [COLOR_W-1:0]        point_color;

    modport source (
        output valid, operation, pos_x, pos_y, depth_z, point_color,
        input  ready
    );
    modport sink (
        input  valid, operation, pos_x, pos_y, depth_z, point_color,
        output ready
    );
endinterface

`default_nettype wire

/* design/pzb_px_if.sv */
// Output channel interface: one status and pixel write per transaction.
// Depends on pzb_pkg.
`default_nettype none

interface pzb_px_if import pzb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;

    modport source (
        output valid, status, pixel_x, pixel_y, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, status, pixel_x, pixel_y, pixel_color,
        output ready
    );
endinterface

`default_nettype wire

/* design/pzb_ctrl.sv */
// Controller state machine: sequences clearing, projection, depth test and result.
// Depends on pzb_pkg; drives pzb_datapath through t_dp_cmd.
`default_nettype none

module pzb_ctrl import pzb_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIVCHK,
        S_DIV,
        S_ROUND,
        S_ADDR,
        S_READ,
        S_CMP,
        S_FINISH
    } t_state;

    t_state  r_state;
    logic    r_out_valid;
    logic    r_axis;
    logic    r_emit;
    t_status r_status;
    logic    w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Commands decoded from the current state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.axis     = r_axis;
        o_cmd.status   = r_status;
        o_cmd.cap_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.clr_step = (r_state == S_CLEAR);
        o_cmd.mul_go   = (r_state == S_MUL);
        o_cmd.div_load = (r_state == S_DIVCHK);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.round_go = (r_state == S_ROUND);
        o_cmd.addr_go  = (r_state == S_ADDR);
        o_cmd.depth_wr = (r_state == S_CMP) && i_stat.depth_win;
        o_cmd.out_load = (r_state == S_FINISH) && w_out_free;
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_axis      <= 1'b0;
            r_emit      <= 1'b0;
            r_status    <= STAT_DRAWN;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (i_stat.sweep_last) begin
                        r_status <= STAT_CLEARED;
                        r_state  <= r_emit ? S_FINISH : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_axis <= 1'b0;
                    if (i_stat.is_clear) begin
                        r_emit  <= 1'b1;
                        r_state <= S_CLEAR;
                    end else if (i_stat.too_near) begin
                        r_status <= STAT_HIDDEN;
                        r_state  <= S_FINISH;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIVCHK;
                end
                S_DIVCHK: begin
                    if (i_stat.div_ovf) begin
                        r_status <= STAT_OFF;
                        r_state  <= S_FINISH;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_last) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    if (i_stat.off_screen) begin
                        r_status <= STAT_OFF;
                        r_state  <= S_FINISH;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_status <= i_stat.depth_win ? STAT_DRAWN : STAT_HIDDEN;
                    r_state  <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_emit  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/pzb_datapath.sv */
// Datapath: configuration registers, multiplier, iterative divider, rounding,
// depth memory and result register. Depends on pzb_pkg; controlled by pzb_ctrl.
`default_nettype none

module pzb_datapath import pzb_pkg::*; #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  wire t_dp_cmd                   i_cmd,
    output t_dp_stat                       o_stat,
    input  wire logic                      i_operation,
    input  wire logic signed [COORD_W-1:0] i_pos_x,
    input  wire logic signed [COORD_W-1:0] i_pos_y,
    input  wire logic signed [COORD_W-1:0] i_depth_z,
    input  wire logic [COLOR_W-1:0]        i_point_color,
    output logic [1:0]                     o_status,
    output logic [PIX_X_W-1:0]             o_pixel_x,
    output logic [PIX_Y_W-1:0]             o_pixel_y,
    output logic [COLOR_W-1:0]             o_pixel_color
);

    localparam int SIZE   = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(PIXELS);
    localparam int XW     = $clog2(SCREEN_WIDTH);
    localparam int YW     = $clog2(SCREEN_HEIGHT);
    localparam logic              SIZE_ODD = (SIZE % 2) == 1;
    localparam logic signed [POS_W-1:0] HALF  = POS_W'(SIZE / 2);
    localparam logic signed [POS_W-1:0] OFF_X = POS_W'((SIZE - SCREEN_WIDTH) / 2);
    localparam logic signed [POS_W-1:0] OFF_Y = POS_W'((SIZE - SCREEN_HEIGHT) / 2);
    localparam logic signed [POS_W-1:0] W_LIM = POS_W'(SCREEN_WIDTH);
    localparam logic signed [POS_W-1:0] H_LIM = POS_W'(SCREEN_HEIGHT);
    localparam int OVF_W  = PROD_W - FRAC_W - QBITS;
    localparam int T_W    = Z_W + FRAC_W + 1;

    // Configuration registers.
    logic [SCALE_W-1:0] r_scale;
    logic [NEAR_W-1:0]  r_near;

    // Captured request.
    logic                      r_op;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic [COLOR_W-1:0]        r_color;

    // Projection arithmetic.
    logic [PROD_W-1:0]       r_prod;
    logic                    r_neg;
    logic [Z_W-1:0]          r_rem;
    logic [QBITS-1:0]        r_dvd;
    logic [QBITS-1:0]        r_quot;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;

    // Depth memory and its addressing.
    logic [DEPTH_W-1:0] r_depth_ram [PIXELS];
    logic [DEPTH_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_sweep;

    // Result register.
    logic [1:0]         r_o_status;
    logic [PIX_X_W-1:0] r_o_x;
    logic [PIX_Y_W-1:0] r_o_y;
    logic [COLOR_W-1:0] r_o_color;

    logic [Z_W-1:0]          w_z;
    logic signed [COORD_W-1:0] w_coord;
    logic [COORD_W-1:0]      w_mag;
    logic [Z_W:0]            w_trial;
    logic                    w_qbit;
    logic [T_W-1:0]          w_t;
    logic [T_W-1:0]          w_d;
    logic                    w_t_gt;
    logic                    w_t_lt;
    logic                    w_t_zero;
    logic signed [POS_W-1:0] w_q;
    logic signed [POS_W-1:0] w_base;
    logic signed [POS_W-1:0] w_lowr;
    logic signed [POS_W-1:0] w_rnd;
    logic [ADDR_W-1:0]       n_addr;
    logic                    w_we;
    logic [ADDR_W-1:0]       w_wr_addr;
    logic [DEPTH_W-1:0]      w_wr_data;

    assign w_z = r_z[Z_W-1:0];

    // Status toward the controller.
    always_comb begin
        o_stat.is_clear   = r_op;
        o_stat.too_near   = r_z <= $signed({1'b0, r_near});
        o_stat.div_ovf    = r_prod[PROD_W-1 -: OVF_W] >= OVF_W'(w_z);
        o_stat.div_last   = r_cnt == CNT_W'(QBITS - 1);
        o_stat.off_screen = r_px[POS_W-1] || (r_px >= W_LIM) ||
                            r_py[POS_W-1] || (r_py >= H_LIM);
        o_stat.depth_win  = {1'b0, w_z} < r_rd_data;
        o_stat.sweep_last = r_sweep == ADDR_W'(PIXELS - 1);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_near  <= NEAR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIXEL_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_NEAR_LIMIT:  r_near  <= i_cfg_data[NEAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op    <= i_operation;
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_z     <= i_depth_z;
            r_color <= i_point_color;
        end
    end

    // Magnitude of the selected coordinate times the scale.
    assign w_coord = i_cmd.axis ? r_y : r_x;
    assign w_mag   = w_coord[COORD_W-1] ? COORD_W'(-w_coord) : COORD_W'(w_coord);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_prod <= PROD_W'(w_mag) * PROD_W'(r_scale);
            r_neg  <= w_coord[COORD_W-1];
        end
    end

    // Restoring divider by the depth, one quotient bit per cycle. The part of
    // the product above the kept quotient bits starts as the remainder.
    assign w_trial = {r_rem, r_dvd[QBITS-1]};
    assign w_qbit  = w_trial >= {1'b0, w_z};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem  <= r_prod[PROD_W-OVF_W+Z_W-1 -: Z_W];
            r_dvd  <= r_prod[FRAC_W +: QBITS];
            r_quot <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_qbit ? Z_W'(w_trial - {1'b0, w_z}) : w_trial[Z_W-1:0];
            r_dvd  <= {r_dvd[QBITS-2:0], 1'b0};
            r_quot <= {r_quot[QBITS-2:0], w_qbit};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    // Rounding to the nearest pixel, ties away from zero. Twice the fraction
    // is compared against the divisor scaled to the same weight.
    assign w_t      = {r_rem, r_prod[FRAC_W-1:0], 1'b0};
    assign w_d      = {1'b0, w_z, {FRAC_W{1'b0}}};
    assign w_t_gt   = w_t > w_d;
    assign w_t_lt   = w_t < w_d;
    assign w_t_zero = w_t == '0;
    assign w_q      = POS_W'(r_quot);
    assign w_base   = r_neg ? (HALF - w_q) : (HALF + w_q);
    assign w_lowr   = w_base - POS_W'(1);

    always_comb begin
        if (!r_neg) begin
            if (SIZE_ODD) begin
                w_rnd = w_base + POS_W'(1);
            end else begin
                w_rnd = w_base + POS_W'(!w_t_lt);
            end
        end else if (!SIZE_ODD) begin
            // Negative value on an even screen: the floor lies one lower
            // unless the fraction is zero.
            if (w_t_zero) begin
                w_rnd = w_base;
            end else if (!w_lowr[POS_W-1]) begin
                w_rnd = w_lowr + POS_W'(!w_t_gt);
            end else begin
                w_rnd = w_lowr + POS_W'(w_t_lt);
            end
        end else begin
            // Negative value on an odd screen, with the half pixel added.
            if (w_t_gt) begin
                w_rnd = w_base;
            end else begin
                w_rnd = w_base + POS_W'(w_t_zero && !w_base[POS_W-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round_go) begin
            if (i_cmd.axis) begin
                r_py <= w_rnd - OFF_Y;
            end else begin
                r_px <= w_rnd - OFF_X;
            end
        end
    end

    // Pixel address, row major.
    assign n_addr = ADDR_W'(ADDR_W'(r_py[YW-1:0]) * ADDR_W'(SCREEN_WIDTH)) +
                    ADDR_W'(r_px[XW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr_go) begin
            r_addr <= n_addr;
        end
    end

    // Clearing sweep counter; it wraps to zero after the last pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.clr_step) begin
            r_sweep <= o_stat.sweep_last ? '0 : r_sweep + ADDR_W'(1);
        end
    end

    // Depth memory: one write port shared by the sweep and the depth update,
    // one registered read port.
    assign w_we      = i_cmd.clr_step || i_cmd.depth_wr;
    assign w_wr_addr = i_cmd.clr_step ? r_sweep : r_addr;
    assign w_wr_data = i_cmd.clr_step ? FAR_DEPTH : {1'b0, w_z};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_depth_ram[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_depth_ram[r_addr];
    end

    // Result register; pixel fields are zero unless the point is drawn.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.status;
            if (i_cmd.status == STAT_DRAWN) begin
                r_o_x     <= r_px[PIX_X_W-1:0];
                r_o_y     <= r_py[PIX_Y_W-1:0];
                r_o_color <= r_color;
            end else begin
                r_o_x     <= '0;
                r_o_y     <= '0;
                r_o_color <= '0;
            end
        end
    end

    assign o_status      = r_o_status;
    assign o_pixel_x     = r_o_x;
    assign o_pixel_y     = r_o_y;
    assign o_pixel_color = r_o_color;

endmodule

`default_nettype wire

/* design/perspective_zbuffer_point_plot_unit.sv */
// Perspective z-buffer point plotter. After acceptance a plot runs one check step, then for
// each of the two axes a multiply, an overflow check, a division on one shared 13-step
// restoring divider and a rounding step, then a depth memory read-modify-write and one
// result load; the next transaction is taken in the cycle after the result load, so a new
// point is not accepted before the previous result is loaded. A near point goes from the
// check to the result load, a clear sweeps one pixel per cycle, and after reset the same
// sweep runs before the first transaction; configuration writes are taken throughout.
`default_nettype none

module perspective_zbuffer_point_plot_unit import pzb_pkg::*; #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    pzb_pt_if.sink                     i_pt,
    pzb_px_if.source                   o_px
);

    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    logic [1:0] w_status;

    // Sequencing.
    pzb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .o_in_ready  (i_pt.ready),
        .o_out_valid (o_px.valid),
        .i_out_ready (o_px.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // Arithmetic, depth memory and result register.
    pzb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_operation   (i_pt.operation),
        .i_pos_x       (i_pt.pos_x),
        .i_pos_y       (i_pt.pos_y),
        .i_depth_z     (i_pt.depth_z),
        .i_point_color (i_pt.point_color),
        .o_status      (w_status),
        .o_pixel_x     (o_px.pixel_x),
        .o_pixel_y     (o_px.pixel_y),
        .o_pixel_color (o_px.pixel_color)
    );

    assign o_px.status = w_status;

endmodule

`default_nettype wire
